[sv/ris_pkg.sv]
// Shared types, widths and helpers for the ray-sphere intersection core.
package ris_pkg;

    localparam int FRAC_BITS = 16;
    localparam int WORD_BITS = 32;
    localparam int DIR_W     = 18;
    localparam int R_W       = 31;
    localparam int EO_W      = WORD_BITS + 1;
    localparam int DP_W      = EO_W + DIR_W;
    localparam int SQ_W      = 2 * WORD_BITS + 1;
    localparam int DOT_W     = DP_W + 2;
    localparam int V_W       = DOT_W - FRAC_BITS;
    localparam int B_W       = 2 * WORD_BITS + 2;
    localparam int R2_W      = 2 * R_W;
    localparam int V2_W      = 70;
    localparam int DISC_W    = V2_W;
    localparam int D_W       = DISC_W / 2;
    localparam int T_W       = V_W + 1;
    localparam int PR_W      = WORD_BITS + DIR_W;
    localparam int S_W       = B_W;
    localparam int L_W       = S_W / 2;
    localparam int Q_W       = FRAC_BITS + 1;
    localparam int DV_W      = EO_W + FRAC_BITS + 1;
    localparam int NRM_W     = 18;
    localparam int SAT_W     = 40;
    localparam int IDX_W     = 2;

    localparam int FRONT_LAT = 5;
    localparam int POINT_LAT = 6;

    localparam logic [IDX_W-1:0] CFG_CENTER_X = 2'd0;
    localparam logic [IDX_W-1:0] CFG_CENTER_Y = 2'd1;
    localparam logic [IDX_W-1:0] CFG_CENTER_Z = 2'd2;
    localparam logic [IDX_W-1:0] CFG_RADIUS   = 2'd3;

    typedef logic signed [WORD_BITS-1:0] word_t;
    typedef logic signed [DIR_W-1:0]     dir_t;
    typedef logic signed [EO_W-1:0]      eo_t;

    typedef struct packed {
        word_t           cx;
        word_t           cy;
        word_t           cz;
        logic [R_W-1:0]  r;
    } sphere_t;

    typedef struct packed {
        word_t ox;
        word_t oy;
        word_t oz;
        dir_t  dx;
        dir_t  dy;
        dir_t  dz;
    } ray_t;

    typedef struct packed {
        logic                  hit;
        logic signed [V_W-1:0] v;
        ray_t                  ray;
    } front_t;

    typedef struct packed {
        logic  hit;
        word_t ts;
        word_t px;
        word_t py;
        word_t pz;
    } res_t;

    typedef struct packed {
        res_t res;
        eo_t  dfx;
        eo_t  dfy;
        eo_t  dfz;
    } point_t;

    function automatic word_t sat_word(input logic signed [SAT_W-1:0] x);
        logic signed [SAT_W-1:0] hi;
        logic signed [SAT_W-1:0] lo;
        hi = SAT_W'($signed({1'b0, {(WORD_BITS-1){1'b1}}}));
        lo = SAT_W'($signed({1'b1, {(WORD_BITS-1){1'b0}}}));
        if (x > hi)
        begin
            return hi[WORD_BITS-1:0];
        end
        else if (x < lo)
        begin
            return lo[WORD_BITS-1:0];
        end
        return x[WORD_BITS-1:0];
    endfunction

endpackage

[sv/ris_sqrt.sv]
// Pipelined integer square root, one result bit per stage, with a side payload.
module ris_sqrt #(
    parameter int IN_W  = 68,
    parameter int PAY_W = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_vld,
    input  logic [IN_W-1:0]   radicand,
    input  logic [PAY_W-1:0]  in_pay,
    output logic              out_vld,
    output logic [IN_W/2-1:0] root,
    output logic [PAY_W-1:0]  out_pay
);

    localparam int OUT_W = IN_W / 2;
    localparam int REM_W = OUT_W + 2;

    logic [IN_W-1:0]  rad_reg  [OUT_W];
    logic [REM_W-1:0] rem_reg  [OUT_W];
    logic [OUT_W-1:0] root_reg [OUT_W];
    logic [PAY_W-1:0] pay_reg  [OUT_W];
    logic             vld_reg  [OUT_W];

    for (genvar k = 0; k < OUT_W; k++)
    begin : g_stage
        logic [IN_W-1:0]  rad_in;
        logic [REM_W-1:0] rem_in;
        logic [OUT_W-1:0] root_in;
        logic [PAY_W-1:0] pay_in;
        logic             vld_in;
        logic [REM_W-1:0] cur;
        logic [REM_W-1:0] trial;
        logic [REM_W-1:0] rem_next;
        logic [OUT_W-1:0] root_next;

        if (k == 0)
        begin : g_first
            assign rad_in  = radicand;
            assign rem_in  = '0;
            assign root_in = '0;
            assign pay_in  = in_pay;
            assign vld_in  = in_vld;
        end
        else
        begin : g_next
            assign rad_in  = rad_reg[k-1];
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
            assign pay_in  = pay_reg[k-1];
            assign vld_in  = vld_reg[k-1];
        end

        always_comb
        begin
            cur   = {rem_in[REM_W-3:0], rad_in[IN_W-1:IN_W-2]};
            trial = {root_in, 2'b01};
            if (cur >= trial)
            begin
                rem_next  = cur - trial;
                root_next = {root_in[OUT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = cur;
                root_next = {root_in[OUT_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else
            begin
                vld_reg[k] <= vld_in;
            end
        end

        always_ff @(posedge clk)
        begin
            rad_reg[k]  <= {rad_in[IN_W-3:0], 2'b00};
            rem_reg[k]  <= rem_next;
            root_reg[k] <= root_next;
            pay_reg[k]  <= pay_in;
        end
    end

    assign out_vld = vld_reg[OUT_W-1];
    assign root    = root_reg[OUT_W-1];
    assign out_pay = pay_reg[OUT_W-1];

endmodule

[sv/ris_front.sv]
// Front stages: center offset, dot product, squared lengths and discriminant.
module ris_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_vld,
    input  ris_pkg::ray_t    ray,
    input  ris_pkg::sphere_t sph,
    output logic             out_vld,
    output logic [ris_pkg::DISC_W-1:0] disc,
    output ris_pkg::front_t  out
);

    localparam int EO_W   = ris_pkg::EO_W;
    localparam int DP_W   = ris_pkg::DP_W;
    localparam int SQ_W   = ris_pkg::SQ_W;
    localparam int DOT_W  = ris_pkg::DOT_W;
    localparam int V_W    = ris_pkg::V_W;
    localparam int B_W    = ris_pkg::B_W;
    localparam int R2_W   = ris_pkg::R2_W;
    localparam int V2_W   = ris_pkg::V2_W;
    localparam int DISC_W = ris_pkg::DISC_W;
    localparam int FB     = ris_pkg::FRAC_BITS;

    logic signed [EO_W-1:0] eo_next [3];
    ris_pkg::word_t         cen [3];
    ris_pkg::word_t         org [3];
    ris_pkg::dir_t          dir [3];

    logic                   s1_vld_reg;
    logic signed [EO_W-1:0] s1_eo_reg [3];
    ris_pkg::ray_t          s1_ray_reg;
    logic [ris_pkg::R_W-1:0] s1_r_reg;

    logic                   s2_vld_reg;
    logic signed [DP_W-1:0] s2_dp_reg [3];
    logic [SQ_W-1:0]        s2_sq_reg [3];
    logic [R2_W-1:0]        s2_r2_reg;
    ris_pkg::ray_t          s2_ray_reg;

    logic                   s3_vld_reg;
    logic signed [V_W-1:0]  s3_v_reg;
    logic [B_W-1:0]         s3_b_reg;
    logic [R2_W-1:0]        s3_r2_reg;
    ris_pkg::ray_t          s3_ray_reg;

    logic                   s4_vld_reg;
    logic signed [V_W-1:0]  s4_v_reg;
    logic [V2_W-1:0]        s4_v2_reg;
    logic [B_W-1:0]         s4_b_reg;
    logic [R2_W-1:0]        s4_r2_reg;
    ris_pkg::ray_t          s4_ray_reg;

    logic                   s5_vld_reg;
    logic [DISC_W-1:0]      s5_disc_reg;
    ris_pkg::front_t        s5_out_reg;

    logic signed [2*EO_W-1:0] sq_full [3];
    logic signed [DOT_W-1:0]  dot;
    logic [B_W-1:0]           b_sum;
    logic signed [2*V_W-1:0]  v_full;
    logic [V2_W:0]            a_sum;
    logic [V2_W:0]            a_diff;

    always_comb
    begin
        cen[0] = sph.cx;
        cen[1] = sph.cy;
        cen[2] = sph.cz;
        org[0] = ray.ox;
        org[1] = ray.oy;
        org[2] = ray.oz;
        dir[0] = ray.dx;
        dir[1] = ray.dy;
        dir[2] = ray.dz;
        for (int i = 0; i < 3; i++)
        begin
            eo_next[i] = $signed({cen[i][ris_pkg::WORD_BITS-1], cen[i]})
                       - $signed({org[i][ris_pkg::WORD_BITS-1], org[i]});
        end
        for (int i = 0; i < 3; i++)
        begin
            sq_full[i] = (2*EO_W)'(s1_eo_reg[i]) * (2*EO_W)'(s1_eo_reg[i]);
        end
        dot    = DOT_W'(s2_dp_reg[0]) + DOT_W'(s2_dp_reg[1]) + DOT_W'(s2_dp_reg[2]);
        b_sum  = B_W'(s2_sq_reg[0]) + B_W'(s2_sq_reg[1]) + B_W'(s2_sq_reg[2]);
        v_full = (2*V_W)'(s3_v_reg) * (2*V_W)'(s3_v_reg);
        a_sum  = (V2_W+1)'(s4_r2_reg) + (V2_W+1)'(s4_v2_reg);
        a_diff = a_sum - (V2_W+1)'(s4_b_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
            s4_vld_reg <= 1'b0;
            s5_vld_reg <= 1'b0;
        end
        else
        begin
            s1_vld_reg <= in_vld;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
            s4_vld_reg <= s3_vld_reg;
            s5_vld_reg <= s4_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            s1_eo_reg[i] <= eo_next[i];
            s2_sq_reg[i] <= sq_full[i][SQ_W-1:0];
        end
        s2_dp_reg[0] <= DP_W'(s1_eo_reg[0]) * DP_W'(s1_ray_reg.dx);
        s2_dp_reg[1] <= DP_W'(s1_eo_reg[1]) * DP_W'(s1_ray_reg.dy);
        s2_dp_reg[2] <= DP_W'(s1_eo_reg[2]) * DP_W'(s1_ray_reg.dz);
        s1_ray_reg <= ray;
        s1_r_reg   <= sph.r;
        s2_r2_reg  <= R2_W'(s1_r_reg) * R2_W'(s1_r_reg);
        s2_ray_reg <= s1_ray_reg;
        s3_v_reg   <= dot[DOT_W-1:FB];
        s3_b_reg   <= b_sum;
        s3_r2_reg  <= s2_r2_reg;
        s3_ray_reg <= s2_ray_reg;
        s4_v_reg   <= s3_v_reg;
        s4_v2_reg  <= v_full[V2_W-1:0];
        s4_b_reg   <= s3_b_reg;
        s4_r2_reg  <= s3_r2_reg;
        s4_ray_reg <= s3_ray_reg;
        s5_disc_reg    <= a_diff[DISC_W-1:0];
        s5_out_reg.hit <= (a_sum >= (V2_W+1)'(s4_b_reg));
        s5_out_reg.v   <= s4_v_reg;
        s5_out_reg.ray <= s4_ray_reg;
    end

    assign out_vld = s5_vld_reg;
    assign disc    = s5_disc_reg;
    assign out     = s5_out_reg;

endmodule

[sv/ris_point.sv]
// Root choice, hit point, offset from center and its squared length.
module ris_point (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_vld,
    input  logic [ris_pkg::D_W-1:0] d,
    input  ris_pkg::front_t  in,
    input  ris_pkg::sphere_t sph,
    output logic             out_vld,
    output logic [ris_pkg::S_W-1:0] s,
    output ris_pkg::point_t  out
);

    localparam int V_W   = ris_pkg::V_W;
    localparam int D_W   = ris_pkg::D_W;
    localparam int T_W   = ris_pkg::T_W;
    localparam int PR_W  = ris_pkg::PR_W;
    localparam int EO_W  = ris_pkg::EO_W;
    localparam int SQ_W  = ris_pkg::SQ_W;
    localparam int S_W   = ris_pkg::S_W;
    localparam int SAT_W = ris_pkg::SAT_W;
    localparam int WB    = ris_pkg::WORD_BITS;
    localparam int FB    = ris_pkg::FRAC_BITS;

    logic signed [T_W-1:0]  t1;
    logic signed [T_W-1:0]  t2;
    logic signed [T_W-1:0]  t_sel;
    logic signed [PR_W-FB-1:0] q [3];
    logic signed [WB+2:0]   psum [3];
    ris_pkg::word_t         pnt [3];
    ris_pkg::word_t         org [3];
    logic signed [2*EO_W-1:0] sq_full [3];

    logic                  p1_vld_reg;
    ris_pkg::word_t        p1_ts_reg;
    logic                  p1_hit_reg;
    ris_pkg::ray_t         p1_ray_reg;

    logic                  p2_vld_reg;
    logic signed [PR_W-1:0] p2_pr_reg [3];
    ris_pkg::word_t        p2_ts_reg;
    logic                  p2_hit_reg;
    ris_pkg::ray_t         p2_ray_reg;

    logic                  p3_vld_reg;
    ris_pkg::res_t         p3_res_reg;

    logic                  p4_vld_reg;
    ris_pkg::point_t       p4_pt_reg;

    logic                  p5_vld_reg;
    logic [SQ_W-1:0]       p5_sq_reg [3];
    ris_pkg::point_t       p5_pt_reg;

    logic                  p6_vld_reg;
    logic [S_W-1:0]        p6_s_reg;
    ris_pkg::point_t       p6_pt_reg;

    always_comb
    begin
        t1    = $signed({in.v[V_W-1], in.v}) - $signed({{(T_W-D_W){1'b0}}, d});
        t2    = $signed({in.v[V_W-1], in.v}) + $signed({{(T_W-D_W){1'b0}}, d});
        t_sel = (t1 > $signed(T_W'(0))) ? t1 : t2;
        org[0] = p2_ray_reg.ox;
        org[1] = p2_ray_reg.oy;
        org[2] = p2_ray_reg.oz;
        for (int i = 0; i < 3; i++)
        begin
            // floor of the scaled product is an arithmetic shift
            q[i]    = p2_pr_reg[i][PR_W-1:FB];
            psum[i] = (WB+3)'(org[i]) + (WB+3)'(q[i]);
            pnt[i]  = ris_pkg::sat_word(SAT_W'(psum[i]));
        end
        sq_full[0] = (2*EO_W)'(p4_pt_reg.dfx) * (2*EO_W)'(p4_pt_reg.dfx);
        sq_full[1] = (2*EO_W)'(p4_pt_reg.dfy) * (2*EO_W)'(p4_pt_reg.dfy);
        sq_full[2] = (2*EO_W)'(p4_pt_reg.dfz) * (2*EO_W)'(p4_pt_reg.dfz);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_vld_reg <= 1'b0;
            p2_vld_reg <= 1'b0;
            p3_vld_reg <= 1'b0;
            p4_vld_reg <= 1'b0;
            p5_vld_reg <= 1'b0;
            p6_vld_reg <= 1'b0;
        end
        else
        begin
            p1_vld_reg <= in_vld;
            p2_vld_reg <= p1_vld_reg;
            p3_vld_reg <= p2_vld_reg;
            p4_vld_reg <= p3_vld_reg;
            p5_vld_reg <= p4_vld_reg;
            p6_vld_reg <= p5_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        p1_ts_reg  <= ris_pkg::sat_word(SAT_W'(t_sel));
        p1_hit_reg <= in.hit;
        p1_ray_reg <= in.ray;

        p2_pr_reg[0] <= PR_W'(p1_ts_reg) * PR_W'(p1_ray_reg.dx);
        p2_pr_reg[1] <= PR_W'(p1_ts_reg) * PR_W'(p1_ray_reg.dy);
        p2_pr_reg[2] <= PR_W'(p1_ts_reg) * PR_W'(p1_ray_reg.dz);
        p2_ts_reg    <= p1_ts_reg;
        p2_hit_reg   <= p1_hit_reg;
        p2_ray_reg   <= p1_ray_reg;

        p3_res_reg.hit <= p2_hit_reg;
        p3_res_reg.ts  <= p2_ts_reg;
        p3_res_reg.px  <= pnt[0];
        p3_res_reg.py  <= pnt[1];
        p3_res_reg.pz  <= pnt[2];

        p4_pt_reg.res <= p3_res_reg;
        p4_pt_reg.dfx <= EO_W'(p3_res_reg.px) - EO_W'($signed(sph.cx));
        p4_pt_reg.dfy <= EO_W'(p3_res_reg.py) - EO_W'($signed(sph.cy));
        p4_pt_reg.dfz <= EO_W'(p3_res_reg.pz) - EO_W'($signed(sph.cz));

        for (int i = 0; i < 3; i++)
        begin
            p5_sq_reg[i] <= sq_full[i][SQ_W-1:0];
        end
        p5_pt_reg <= p4_pt_reg;

        p6_s_reg  <= S_W'(p5_sq_reg[0]) + S_W'(p5_sq_reg[1]) + S_W'(p5_sq_reg[2]);
        p6_pt_reg <= p5_pt_reg;
    end

    assign out_vld = p6_vld_reg;
    assign s       = p6_s_reg;
    assign out     = p6_pt_reg;

endmodule

[sv/ris_norm.sv]
// Normal divider: three restoring dividers in lockstep, one quotient bit per stage.
module ris_norm #(
    parameter int PAY_W = 8
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_vld,
    input  logic [ris_pkg::L_W-1:0]  len,
    input  ris_pkg::eo_t             dfx,
    input  ris_pkg::eo_t             dfy,
    input  ris_pkg::eo_t             dfz,
    input  logic [PAY_W-1:0]         in_pay,
    output logic                     out_vld,
    output logic signed [ris_pkg::NRM_W-1:0] normal_x,
    output logic signed [ris_pkg::NRM_W-1:0] normal_y,
    output logic signed [ris_pkg::NRM_W-1:0] normal_z,
    output logic [PAY_W-1:0]         out_pay
);

    localparam int Q_W   = ris_pkg::Q_W;
    localparam int DV_W  = ris_pkg::DV_W;
    localparam int L_W   = ris_pkg::L_W;
    localparam int EO_W  = ris_pkg::EO_W;
    localparam int NRM_W = ris_pkg::NRM_W;
    localparam int FB    = ris_pkg::FRAC_BITS;

    logic [DV_W-1:0]  rem_reg [Q_W][3];
    logic [Q_W-1:0]   quo_reg [Q_W][3];
    logic             neg_reg [Q_W][3];
    logic [L_W-1:0]   len_reg [Q_W];
    logic [PAY_W-1:0] pay_reg [Q_W];
    logic             vld_reg [Q_W];

    ris_pkg::eo_t     df_in [3];
    logic signed [NRM_W-1:0] nrm [3];

    assign df_in[0] = dfx;
    assign df_in[1] = dfy;
    assign df_in[2] = dfz;

    for (genvar k = 0; k < Q_W; k++)
    begin : g_stage
        logic [DV_W-1:0]  rem_in [3];
        logic [Q_W-1:0]   quo_in [3];
        logic             neg_in [3];
        logic [L_W-1:0]   len_in;
        logic [PAY_W-1:0] pay_in;
        logic             vld_in;
        logic [DV_W-1:0]  trial;

        if (k == 0)
        begin : g_first
            logic [EO_W-1:0] mag [3];
            always_comb
            begin
                for (int i = 0; i < 3; i++)
                begin
                    mag[i]    = df_in[i][EO_W-1] ? EO_W'(-df_in[i]) : EO_W'(df_in[i]);
                    rem_in[i] = DV_W'({mag[i], {FB{1'b0}}});
                    quo_in[i] = '0;
                    neg_in[i] = df_in[i][EO_W-1];
                end
            end
            assign len_in = len;
            assign pay_in = in_pay;
            assign vld_in = in_vld;
        end
        else
        begin : g_next
            always_comb
            begin
                for (int i = 0; i < 3; i++)
                begin
                    rem_in[i] = rem_reg[k-1][i];
                    quo_in[i] = quo_reg[k-1][i];
                    neg_in[i] = neg_reg[k-1][i];
                end
            end
            assign len_in = len_reg[k-1];
            assign pay_in = pay_reg[k-1];
            assign vld_in = vld_reg[k-1];
        end

        assign trial = DV_W'(len_in) << (Q_W - 1 - k);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else
            begin
                vld_reg[k] <= vld_in;
            end
        end

        always_ff @(posedge clk)
        begin
            for (int i = 0; i < 3; i++)
            begin
                if (rem_in[i] >= trial)
                begin
                    rem_reg[k][i] <= rem_in[i] - trial;
                    quo_reg[k][i] <= {quo_in[i][Q_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[k][i] <= rem_in[i];
                    quo_reg[k][i] <= {quo_in[i][Q_W-2:0], 1'b0};
                end
                neg_reg[k][i] <= neg_in[i];
            end
            len_reg[k] <= len_in;
            pay_reg[k] <= pay_in;
        end
    end

    // quotient never exceeds one in Q1.16, so it fits the signed 18-bit field as is
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (len_reg[Q_W-1] == '0)
            begin
                nrm[i] = '0;
            end
            else if (neg_reg[Q_W-1][i])
            begin
                nrm[i] = -$signed(NRM_W'(quo_reg[Q_W-1][i]));
            end
            else
            begin
                nrm[i] = $signed(NRM_W'(quo_reg[Q_W-1][i]));
            end
        end
    end

    assign out_vld  = vld_reg[Q_W-1];
    assign normal_x = nrm[0];
    assign normal_y = nrm[1];
    assign normal_z = nrm[2];
    assign out_pay  = pay_reg[Q_W-1];

endmodule

[sv/ray_sphere_intersect_core.sv]
// Top level of the ray-sphere intersection core: config registers, pipeline, result beat.
//
//  channel | handshake     | payload
//  --------+---------------+------------------------------------------------
//  ray in  | start / busy  | origin_x/y/z, dir_x/y/z
//  result  | done (strobe) | hit, hit_distance, point_x/y/z, normal_x/y/z
//  config  | cfg_we        | cfg_index, cfg_data
//
// One ray is taken every cycle; busy stays low. A ray passes through 5 front stages,
// the two bit-serial square-root pipelines (35 and 33 stages) around 6 point stages,
// then the 17-stage normal divider and the result register.
// Reset clears the config registers (radius 1.0) and all valid bits.
// The result beat is shown for one cycle; nothing holds it back.
module ray_sphere_intersect_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic                              cfg_we,
    input  logic [ris_pkg::IDX_W-1:0]         cfg_index,
    input  logic [ris_pkg::WORD_BITS-1:0]     cfg_data,
    input  logic signed [ris_pkg::WORD_BITS-1:0] origin_x,
    input  logic signed [ris_pkg::WORD_BITS-1:0] origin_y,
    input  logic signed [ris_pkg::WORD_BITS-1:0] origin_z,
    input  logic signed [ris_pkg::DIR_W-1:0]  dir_x,
    input  logic signed [ris_pkg::DIR_W-1:0]  dir_y,
    input  logic signed [ris_pkg::DIR_W-1:0]  dir_z,
    output logic                              done,
    output logic                              hit,
    output logic signed [ris_pkg::WORD_BITS-1:0] hit_distance,
    output logic signed [ris_pkg::WORD_BITS-1:0] point_x,
    output logic signed [ris_pkg::WORD_BITS-1:0] point_y,
    output logic signed [ris_pkg::WORD_BITS-1:0] point_z,
    output logic signed [ris_pkg::NRM_W-1:0]  normal_x,
    output logic signed [ris_pkg::NRM_W-1:0]  normal_y,
    output logic signed [ris_pkg::NRM_W-1:0]  normal_z
);

    localparam int FRONT_W = $bits(ris_pkg::front_t);
    localparam int POINT_W = $bits(ris_pkg::point_t);
    localparam int RES_W   = $bits(ris_pkg::res_t);
    localparam int NRM_W   = ris_pkg::NRM_W;
    localparam int TOTAL_LAT = ris_pkg::FRONT_LAT + ris_pkg::D_W + ris_pkg::POINT_LAT
                             + ris_pkg::L_W + ris_pkg::Q_W + 1;

    ris_pkg::sphere_t sph_reg;
    ris_pkg::ray_t    ray;

    logic                         fr_vld;
    logic [ris_pkg::DISC_W-1:0]   fr_disc;
    ris_pkg::front_t              fr_out;
    logic                         sq1_vld;
    logic [ris_pkg::D_W-1:0]      sq1_root;
    logic [FRONT_W-1:0]           sq1_pay;
    logic                         pt_vld;
    logic [ris_pkg::S_W-1:0]      pt_s;
    ris_pkg::point_t              pt_out;
    logic                         sq2_vld;
    logic [ris_pkg::L_W-1:0]      sq2_root;
    logic [POINT_W-1:0]           sq2_pay;
    ris_pkg::point_t              sq2_pt;
    logic                         nm_vld;
    logic signed [NRM_W-1:0]      nm_x;
    logic signed [NRM_W-1:0]      nm_y;
    logic signed [NRM_W-1:0]      nm_z;
    logic [RES_W-1:0]             nm_pay;
    ris_pkg::res_t                nm_res;

    logic                         done_reg;
    ris_pkg::res_t                res_reg;
    logic signed [NRM_W-1:0]      nx_reg;
    logic signed [NRM_W-1:0]      ny_reg;
    logic signed [NRM_W-1:0]      nz_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sph_reg.cx <= '0;
            sph_reg.cy <= '0;
            sph_reg.cz <= '0;
            sph_reg.r  <= ris_pkg::R_W'(1) << ris_pkg::FRAC_BITS;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                ris_pkg::CFG_CENTER_X: sph_reg.cx <= cfg_data;
                ris_pkg::CFG_CENTER_Y: sph_reg.cy <= cfg_data;
                ris_pkg::CFG_CENTER_Z: sph_reg.cz <= cfg_data;
                ris_pkg::CFG_RADIUS:   sph_reg.r  <= cfg_data[ris_pkg::R_W-1:0];
                default:               sph_reg    <= sph_reg;
            endcase
        end
    end

    assign busy   = 1'b0;
    assign ray.ox = origin_x;
    assign ray.oy = origin_y;
    assign ray.oz = origin_z;
    assign ray.dx = dir_x;
    assign ray.dy = dir_y;
    assign ray.dz = dir_z;

    ris_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_vld  (start & ~busy),
        .ray     (ray),
        .sph     (sph_reg),
        .out_vld (fr_vld),
        .disc    (fr_disc),
        .out     (fr_out)
    );

    ris_sqrt #(
        .IN_W  (ris_pkg::DISC_W),
        .PAY_W (FRONT_W)
    ) u_sqrt_disc (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_vld   (fr_vld),
        .radicand (fr_disc),
        .in_pay   (fr_out),
        .out_vld  (sq1_vld),
        .root     (sq1_root),
        .out_pay  (sq1_pay)
    );

    ris_point u_point (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_vld  (sq1_vld),
        .d       (sq1_root),
        .in      (ris_pkg::front_t'(sq1_pay)),
        .sph     (sph_reg),
        .out_vld (pt_vld),
        .s       (pt_s),
        .out     (pt_out)
    );

    ris_sqrt #(
        .IN_W  (ris_pkg::S_W),
        .PAY_W (POINT_W)
    ) u_sqrt_len (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_vld   (pt_vld),
        .radicand (pt_s),
        .in_pay   (pt_out),
        .out_vld  (sq2_vld),
        .root     (sq2_root),
        .out_pay  (sq2_pay)
    );

    assign sq2_pt = ris_pkg::point_t'(sq2_pay);

    ris_norm #(
        .PAY_W (RES_W)
    ) u_norm (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_vld   (sq2_vld),
        .len      (sq2_root),
        .dfx      (sq2_pt.dfx),
        .dfy      (sq2_pt.dfy),
        .dfz      (sq2_pt.dfz),
        .in_pay   (sq2_pt.res),
        .out_vld  (nm_vld),
        .normal_x (nm_x),
        .normal_y (nm_y),
        .normal_z (nm_z),
        .out_pay  (nm_pay)
    );

    assign nm_res = ris_pkg::res_t'(nm_pay);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= nm_vld;
        end
    end

    // drop everything but the flag on a miss
    always_ff @(posedge clk)
    begin
        if (nm_res.hit)
        begin
            res_reg <= nm_res;
            nx_reg  <= nm_x;
            ny_reg  <= nm_y;
            nz_reg  <= nm_z;
        end
        else
        begin
            res_reg <= '0;
            nx_reg  <= '0;
            ny_reg  <= '0;
            nz_reg  <= '0;
        end
    end

    assign done         = done_reg;
    assign hit          = res_reg.hit;
    assign hit_distance = res_reg.ts;
    assign point_x      = res_reg.px;
    assign point_y      = res_reg.py;
    assign point_z      = res_reg.pz;
    assign normal_x     = nx_reg;
    assign normal_y     = ny_reg;
    assign normal_z     = nz_reg;

`ifndef NO_ASSERTIONS
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##TOTAL_LAT done)
        else $error("result beat missing after pipeline latency");

    a_no_stray: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, TOTAL_LAT))
        else $error("result beat without a matching ray");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && !hit |-> hit_distance == 0 && point_x == 0 && normal_x == 0
                         && normal_y == 0 && normal_z == 0)
        else $error("miss beat carries nonzero fields");
`endif

endmodule

[verif/ray_sphere_intersect_core_tb.sv]
// Self-checking testbench for the ray-sphere intersection core.
module ray_sphere_intersect_core_tb;

    typedef struct {
        ris_pkg::word_t ox;
        ris_pkg::word_t oy;
        ris_pkg::word_t oz;
        ris_pkg::dir_t  dx;
        ris_pkg::dir_t  dy;
        ris_pkg::dir_t  dz;
    } ray_beat_t;

    typedef struct packed {
        logic           hit;
        ris_pkg::word_t hit_dist;
        ris_pkg::word_t px;
        ris_pkg::word_t py;
        ris_pkg::word_t pz;
        ris_pkg::dir_t  nx;
        ris_pkg::dir_t  ny;
        ris_pkg::dir_t  nz;
    } hit_beat_t;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic cfg_we;
    logic [ris_pkg::IDX_W-1:0] cfg_index;
    logic [ris_pkg::WORD_BITS-1:0] cfg_data;
    ris_pkg::word_t origin_x, origin_y, origin_z;
    ris_pkg::dir_t dir_x, dir_y, dir_z;
    logic done;
    logic hit;
    ris_pkg::word_t hit_distance, point_x, point_y, point_z;
    ris_pkg::dir_t normal_x, normal_y, normal_z;

    ray_beat_t pending_rays[$];
    hit_beat_t expected_hits[$];
    longint sph_cx, sph_cy, sph_cz, sph_r;
    int gap_pct;
    int rays_sent, hits_seen, misses_seen, mismatches;

    ray_sphere_intersect_core u_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .origin_x(origin_x), .origin_y(origin_y), .origin_z(origin_z),
        .dir_x(dir_x), .dir_y(dir_y), .dir_z(dir_z),
        .done(done), .hit(hit), .hit_distance(hit_distance),
        .point_x(point_x), .point_y(point_y), .point_z(point_z),
        .normal_x(normal_x), .normal_y(normal_y), .normal_z(normal_z)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic logic [63:0] isqrt128(input logic [127:0] n);
        logic [127:0] rem;
        logic [127:0] res;
        logic [127:0] bitv;
        rem = n;
        res = '0;
        bitv = 128'd1 << 126;
        while (bitv != 0 && rem < bitv)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (rem >= res + bitv)
            begin
                rem = rem - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res[63:0];
    endfunction

    function automatic longint clamp_word(input longint x);
        if (x > longint'(32'h7fffffff))
            return longint'(32'h7fffffff);
        if (x < -longint'(33'h080000000))
            return -longint'(33'h080000000);
        return x;
    endfunction

    function automatic hit_beat_t trace_ray(input ray_beat_t r);
        longint o[3], dv[3], c[3], df[3];
        longint eo, dotsum, v, d, t, ts, q, n, len;
        logic signed [127:0] a, b, s, w;
        hit_beat_t h;
        ris_pkg::word_t pw[3];
        ris_pkg::dir_t nw[3];
        o[0] = r.ox; o[1] = r.oy; o[2] = r.oz;
        dv[0] = r.dx; dv[1] = r.dy; dv[2] = r.dz;
        c[0] = sph_cx; c[1] = sph_cy; c[2] = sph_cz;
        dotsum = 0;
        b = 0;
        for (int i = 0; i < 3; i++)
        begin
            eo = c[i] - o[i];
            dotsum += eo * dv[i];
            w = eo;
            b += w * w;
        end
        h = '0;
        v = dotsum >>> ris_pkg::FRAC_BITS;
        w = v;
        a = w * w;
        w = sph_r;
        a += w * w;
        if (a < b)
            return h;
        d = longint'(isqrt128(a - b));
        t = (v - d > 0) ? v - d : v + d;
        ts = clamp_word(t);
        s = 0;
        for (int i = 0; i < 3; i++)
        begin
            q = (ts * dv[i]) >>> ris_pkg::FRAC_BITS;
            pw[i] = ris_pkg::word_t'(clamp_word(o[i] + q));
            df[i] = longint'(pw[i]) - c[i];
            w = df[i];
            s += w * w;
        end
        len = longint'(isqrt128(s));
        for (int i = 0; i < 3; i++)
        begin
            nw[i] = '0;
            if (len != 0)
            begin
                n = ((df[i] < 0 ? -df[i] : df[i]) << ris_pkg::FRAC_BITS) / len;
                if (df[i] < 0)
                    n = -n;
                if (n > 131071)
                    n = 131071;
                if (n < -131072)
                    n = -131072;
                nw[i] = ris_pkg::dir_t'(n);
            end
        end
        h.hit = 1'b1;
        h.hit_dist = ris_pkg::word_t'(ts);
        h.px = pw[0]; h.py = pw[1]; h.pz = pw[2];
        h.nx = nw[0]; h.ny = nw[1]; h.nz = nw[2];
        return h;
    endfunction

    // driver: one beat per edge, random gaps
    always @(posedge clk or negedge rst_n)
    begin
        ray_beat_t nxt;
        if (!rst_n)
        begin
            start <= 1'b0;
            origin_x <= '0; origin_y <= '0; origin_z <= '0;
            dir_x <= '0; dir_y <= '0; dir_z <= '0;
        end
        else if (!start || !busy)
        begin
            if (pending_rays.size() > 0 && $urandom_range(99) >= gap_pct)
            begin
                nxt = pending_rays.pop_front();
                start <= 1'b1;
                origin_x <= nxt.ox; origin_y <= nxt.oy; origin_z <= nxt.oz;
                dir_x <= nxt.dx; dir_y <= nxt.dy; dir_z <= nxt.dz;
            end
            else
                start <= 1'b0;
        end
    end

    // monitor: predict on accepted rays, check each result beat
    always @(posedge clk)
    begin
        ray_beat_t acc;
        hit_beat_t exp_h;
        hit_beat_t got;
        if (rst_n)
        begin
            if (start && !busy)
            begin
                acc = '{origin_x, origin_y, origin_z, dir_x, dir_y, dir_z};
                expected_hits.push_back(trace_ray(acc));
                rays_sent++;
            end
            if (done)
            begin
                got = '{hit, hit_distance, point_x, point_y, point_z,
                        normal_x, normal_y, normal_z};
                if (expected_hits.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: unexpected result beat %p", got);
                end
                else
                begin
                    exp_h = expected_hits.pop_front();
                    if (got.hit)
                        hits_seen++;
                    else
                        misses_seen++;
                    if (got !== exp_h)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("ERROR: result mismatch\n  exp %p\n  got %p", exp_h, got);
                    end
                end
            end
        end
    end

    task automatic write_reg(input logic [ris_pkg::IDX_W-1:0] idx, input longint val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val[31:0];
        case (idx)
            ris_pkg::CFG_CENTER_X: sph_cx = longint'(signed'(val[31:0]));
            ris_pkg::CFG_CENTER_Y: sph_cy = longint'(signed'(val[31:0]));
            ris_pkg::CFG_CENTER_Z: sph_cz = longint'(signed'(val[31:0]));
            ris_pkg::CFG_RADIUS:   sph_r = longint'(val[30:0]);
            default: ;
        endcase
    endtask

    task automatic program_sphere(input longint cx, input longint cy, input longint cz,
                                  input longint r);
        write_reg(ris_pkg::CFG_CENTER_X, cx);
        write_reg(ris_pkg::CFG_CENTER_Y, cy);
        write_reg(ris_pkg::CFG_CENTER_Z, cz);
        write_reg(ris_pkg::CFG_RADIUS, r);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic drain();
        while (pending_rays.size() > 0 || start || expected_hits.size() > 0)
            @(posedge clk);
        repeat (110) @(posedge clk);
    endtask

    task automatic add_ray(input longint ox, input longint oy, input longint oz,
                           input longint dx, input longint dy, input longint dz);
        ray_beat_t r;
        r = '{ris_pkg::word_t'(ox), ris_pkg::word_t'(oy), ris_pkg::word_t'(oz),
              ris_pkg::dir_t'(dx), ris_pkg::dir_t'(dy), ris_pkg::dir_t'(dz)};
        pending_rays.push_back(r);
    endtask

    // signed offset of random bit length
    function automatic longint rnd_span();
        longint x;
        int k;
        k = $urandom_range(33);
        x = longint'({$urandom, $urandom}) & ((longint'(1) << k) - 1);
        return $urandom_range(1) ? -x : x;
    endfunction

    function automatic longint rnd_dir();
        int pick;
        pick = $urandom_range(9);
        if (pick == 0)
            return longint'(signed'(18'($urandom)));
        if (pick < 4)
            return $urandom_range(1) ? 65536 : -65536;
        if (pick < 6)
            return 0;
        return longint'($urandom_range(131072)) - 65536;
    endfunction

    task automatic add_random_rays(input int count);
        longint ox, oy, oz;
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(9) < 8)
            begin
                ox = clamp_word(sph_cx + rnd_span());
                oy = clamp_word(sph_cy + rnd_span());
                oz = clamp_word(sph_cz + rnd_span());
            end
            else
            begin
                ox = longint'(signed'($urandom));
                oy = longint'(signed'($urandom));
                oz = longint'(signed'($urandom));
            end
            add_ray(ox, oy, oz, rnd_dir(), rnd_dir(), rnd_dir());
        end
    endtask

    localparam longint MAXW = 64'sh7fffffff;
    localparam longint MINW = -64'sh80000000;
    localparam longint ONE  = 65536;

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        sph_cx = 0; sph_cy = 0; sph_cz = 0; sph_r = ONE;
        gap_pct = 13;
        rays_sent = 0; hits_seen = 0; misses_seen = 0; mismatches = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // unit sphere at origin, reset values
        add_ray(0, 0, -3 * ONE, 0, 0, ONE);
        add_ray(0, 0, 0, ONE, 0, 0);
        add_ray(0, 0, 3 * ONE, 0, 0, ONE);
        add_ray(0, 5 * ONE, -3 * ONE, 0, 0, ONE);
        add_ray(0, 0, 0, 0, 0, 0);
        add_ray(2 * ONE, 0, 0, 0, 0, 0);
        add_ray(MAXW, MAXW, MAXW, -ONE, -ONE, -ONE);
        add_ray(MINW, MINW, MINW, ONE, ONE, ONE);
        add_ray(MAXW, MINW, 0, -131072, 131071, -1);
        add_ray(-3 * ONE, ONE / 2, 0, ONE, 0, 0);
        add_ray(0, -2 * ONE, 0, 0, ONE, 0);
        add_ray(ONE, 0, 0, 0, ONE, 0);
        add_random_rays(190);
        drain();

        program_sphere(MAXW, MINW, 0, 64'sh7fffffff);
        add_ray(0, 0, 0, ONE, 0, 0);
        add_ray(MAXW, MINW, 0, 0, ONE, 0);
        add_random_rays(200);
        drain();

        gap_pct = 67;
        // zero radius: hitting the center exactly gives a degenerate normal
        program_sphere(MINW, MAXW, MINW, 0);
        add_ray(MINW, MAXW, MINW, ONE, 0, 0);
        add_ray(MINW, MAXW, MINW, 0, 0, 0);
        add_ray(MINW + ONE, MAXW, MINW, -ONE, 0, 0);
        add_random_rays(200);
        drain();

        program_sphere(longint'(signed'($urandom)), longint'(signed'($urandom)),
                       longint'(signed'($urandom)), longint'($urandom & 32'h7fffffff));
        add_random_rays(200);
        drain();

        gap_pct = 0;
        program_sphere(5 * ONE, -7 * ONE, 12 * ONE, 10 * ONE);
        add_random_rays(200);
        drain();

        program_sphere(-ONE, ONE / 3, 0, ONE / 1000);
        add_random_rays(200);
        drain();

        program_sphere(longint'(signed'($urandom)) >>> 8, longint'(signed'($urandom)) >>> 8,
                       longint'(signed'($urandom)) >>> 8, longint'($urandom_range(1 << 24)));
        add_random_rays(200);
        drain();

        $display("Covered %0d rays over 7 sphere settings: %0d hits, %0d misses",
                 rays_sent, hits_seen, misses_seen);
        $display("Mismatches: %0d", mismatches);
        if (mismatches == 0 && expected_hits.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        #1000000;
        $display("Timeout waiting for result beats");
        $display("Regression FAIL");
        $finish;
    end

endmodule

[files.f]
sv/ris_pkg.sv
sv/ris_sqrt.sv
sv/ris_front.sv
sv/ris_point.sv
sv/ris_norm.sv
sv/ray_sphere_intersect_core.sv
verif/ray_sphere_intersect_core_tb.sv
